// ----- rtl/per_channel_dequantizer_top_assert.svh -----
// Assertion macros shared by the dequantizer checker.
// Included by the checker module file only.
`ifndef PER_CHANNEL_DEQUANTIZER_TOP_ASSERT_SVH
`define PER_CHANNEL_DEQUANTIZER_TOP_ASSERT_SVH

// An implication that must hold on every clock edge out of reset.
`define PCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// A next-cycle implication.
`define PCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pcd_pkg.sv -----
// Package for the per-channel dequantizer: constants, types and float helpers.
// Used by pcd_front, pcd_fmul and the top level.
`timescale 1ns / 1ps
package pcd_pkg;
    localparam int MaxChannels = 256;
    localparam int TabAw = $clog2(MaxChannels);

    localparam logic [2:0] REG_VALUE_TYPE    = 3'd0;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [2:0] REG_INNER_SIZE    = 3'd2;
    localparam logic [2:0] REG_PARAM_COUNT   = 3'd3;
    localparam logic [2:0] REG_ELEMENT_COUNT = 3'd4;

    typedef enum logic [2:0] {
        VT_F16 = 3'd0, VT_U4 = 3'd1, VT_S4 = 3'd2, VT_U8 = 3'd3,
        VT_S8 = 3'd4, VT_S16 = 3'd5, VT_S32 = 3'd6, VT_S64 = 3'd7
    } value_type_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] raw_value;
        logic [7:0]  table_index;
        logic [31:0] scale_bits;
        logic [63:0] zero_point;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        last;
    } out_item_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        value_type_t vtype;
        logic [16:0] channel_count;
        logic [24:0] inner_size;
        logic [8:0]  param_count;
        logic [31:0] element_count;
    } cfg_t;

    // Position of the leading one of a nonzero 64-bit value.
    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // Round a left-normalized 64-bit significand (bit 63 set) to single.
    // be is the biased exponent of bit 63; values below 1 go subnormal.
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [11:0] be,
                                               input logic [63:0] sig);
        logic [63:0]  s;
        logic [11:0]  rsh;
        logic         sticky;
        logic [24:0]  m;
        logic         g;
        logic [31:0]  bits;
        logic [32:0]  sum;
        s = sig;
        sticky = 1'b0;
        bits = 32'd0;
        if (be >= 12'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        if (be < 12'sd1) begin
            rsh = 12'(12'sd1 - be);
            if (rsh > 12'd63) begin
                sticky = |s;
                s = 64'd0;
            end else begin
                sticky = |(s & ((64'd1 << rsh[5:0]) - 64'd1));
                s = s >> rsh[5:0];
            end
        end
        // s[63] is the hidden bit position; keep 24 bits then round.
        m = {1'b0, s[63:40]};
        g = s[39];
        sticky = sticky | (|s[38:0]);
        if (g && (sticky || m[0])) begin
            m = m + 25'd1;
        end
        if (be >= 12'sd1) begin
            sum = {1'b0, 32'(be - 12'sd1) << 23} + 33'(m);
        end else begin
            sum = 33'(m);
        end
        if (sum >= 33'h07F800000) begin
            bits = 32'h7F800000;
        end else begin
            bits = sum[31:0];
        end
        return {sign, bits[30:0]};
    endfunction
endpackage

// ----- rtl/pcd_stream_if.sv -----
// Valid/ready stream interface carrying one item of a given payload type.
// Depends on nothing but the payload type given at instantiation.
`timescale 1ns / 1ps
interface pcd_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/pcd_front.sv -----
// Front stage: table memories, channel counters and integer-to-float convert.
// Depends on pcd_pkg.
`timescale 1ns / 1ps
module pcd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  pcd_pkg::cfg_t      cfg,
    input  logic               take,
    input  pcd_pkg::in_item_t  item,
    input  logic               advance,
    output logic               s1_valid,
    output logic [31:0]        s1_value,
    output logic [31:0]        s1_scale,
    output logic               s1_is_f16,
    output logic               s1_last
);
    import pcd_pkg::*;

    logic [31:0] scale_mem [MaxChannels];
    logic [63:0] zero_mem [MaxChannels];

    logic [23:0] inner_reg;
    logic [15:0] chan_reg;
    logic [31:0] elem_reg;

    // Stage 0: registered item plus table read data.
    logic        s0_valid_reg;
    logic [63:0] s0_v_reg;
    logic [15:0] s0_h_reg;
    logic        s0_f16_reg;
    logic        s0_last_reg;
    logic [31:0] s0_scale_reg;
    logic [63:0] s0_zero_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_value_reg;
    logic [31:0] s1_scale_reg;
    logic        s1_f16_reg;
    logic        s1_last_reg;

    logic        is_data;
    logic [63:0] v_ext;
    logic [TabAw-1:0] qd;
    logic        last_now;
    logic [24:0] eff_inner;
    logic [16:0] eff_ch;
    logic [24:0] inner_inc;
    logic [16:0] chan_inc;

    assign is_data = take && item.mode;

    always_comb
    begin
        unique case (cfg.vtype)
            VT_U4:  v_ext = {60'd0, item.raw_value[3:0]};
            VT_S4:  v_ext = {{60{item.raw_value[3]}}, item.raw_value[3:0]};
            VT_U8:  v_ext = {56'd0, item.raw_value[7:0]};
            VT_S8:  v_ext = {{56{item.raw_value[7]}}, item.raw_value[7:0]};
            VT_S16: v_ext = {{48{item.raw_value[15]}}, item.raw_value[15:0]};
            VT_S32: v_ext = {{32{item.raw_value[31]}}, item.raw_value[31:0]};
            default: v_ext = item.raw_value;
        endcase
    end

    always_comb
    begin
        if ({1'b0, chan_reg} >= cfg.param_count || 32'(chan_reg) >= MaxChannels) begin
            qd = '0;
        end else begin
            qd = chan_reg[TabAw-1:0];
        end
        last_now = (elem_reg == cfg.element_count - 32'd1);
        eff_inner = (cfg.inner_size == 25'd0) ? 25'd1 :
                    (cfg.inner_size > 25'h1000000) ? 25'h1000000 : cfg.inner_size;
        eff_ch = (cfg.channel_count == 17'd0) ? 17'd1 :
                 (cfg.channel_count > 17'h10000) ? 17'h10000 : cfg.channel_count;
        inner_inc = {1'b0, inner_reg} + 25'd1;
        chan_inc = {1'b0, chan_reg} + 17'd1;
    end

    always_ff @(posedge clk)
    begin
        if (take && !item.mode && 32'(item.table_index) < MaxChannels) begin
            scale_mem[item.table_index[TabAw-1:0]] <= item.scale_bits;
            zero_mem[item.table_index[TabAw-1:0]]  <= item.zero_point;
        end
    end

    // Table read happens at accept. Loads share the input channel, so any
    // earlier load has already been written by then.
    always_ff @(posedge clk)
    begin
        if (is_data) begin
            s0_v_reg    <= v_ext;
            s0_h_reg    <= item.raw_value[15:0];
            s0_f16_reg  <= (cfg.vtype == VT_F16);
            s0_last_reg <= last_now;
            s0_scale_reg <= scale_mem[qd];
            s0_zero_reg  <= zero_mem[qd];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inner_reg <= '0;
            chan_reg <= '0;
            elem_reg <= '0;
        end else if (is_data) begin
            if (last_now) begin
                inner_reg <= '0;
                chan_reg <= '0;
                elem_reg <= '0;
            end else begin
                elem_reg <= elem_reg + 32'd1;
                if (inner_inc >= eff_inner) begin
                    inner_reg <= '0;
                    chan_reg <= (chan_inc >= eff_ch) ? 16'd0 : chan_inc[15:0];
                end else begin
                    inner_reg <= inner_inc[23:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s0_valid_reg <= is_data;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    // Stage 1: subtract zero point and convert to single, or widen a half to single.
    logic [63:0] diff;
    logic [63:0] mag;
    logic [5:0]  lo;
    logic [63:0] norm;
    logic [31:0] int_f;
    logic [31:0] half_f;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [5:0]  hlo;
    logic [3:0]  hl;

    always_comb
    begin
        diff = s0_v_reg - s0_zero_reg;
        mag = diff[63] ? (64'd0 - diff) : diff;
        lo = lead_one(mag);
        norm = mag << (6'd63 - lo);
        if (diff == 64'd0) begin
            int_f = 32'd0;
        end else begin
            int_f = round_pack(diff[63], 12'(12'sd127 + $signed({6'd0, lo})), norm);
        end
        he = s0_h_reg[14:10];
        hm = s0_h_reg[9:0];
        hlo = lead_one({54'd0, hm});
        hl = hlo[3:0];
        if (he == 5'd31) begin
            half_f = {s0_h_reg[15], 8'hFF, hm != 10'd0, hm[8:0], 13'd0};
        end else if (he == 5'd0) begin
            if (hm == 10'd0) begin
                half_f = {s0_h_reg[15], 31'd0};
            end else begin
                // Subnormal half: exact in single as a normal number.
                half_f = {s0_h_reg[15], 8'(8'd103 + {4'd0, hl}),
                          23'({13'd0, hm} << (5'd23 - {1'b0, hl}))};
            end
        end else begin
            half_f = {s0_h_reg[15], 8'({3'd0, he} + 8'd112), hm, 13'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_value_reg <= s0_f16_reg ? half_f : int_f;
            s1_scale_reg <= s0_scale_reg;
            s1_f16_reg   <= s0_f16_reg;
            s1_last_reg  <= s0_last_reg;
        end
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_value  = s1_value_reg;
    assign s1_scale  = s1_scale_reg;
    assign s1_is_f16 = s1_f16_reg;
    assign s1_last   = s1_last_reg;
endmodule

// ----- rtl/pcd_fmul.sv -----
// Single-precision multiply stage: 24x24 product registered, then rounding.
// Depends on pcd_pkg.
`timescale 1ns / 1ps
module pcd_fmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        bypass,
    input  logic        in_last,
    output logic        out_valid,
    output logic [31:0] result,
    output logic        out_last
);
    import pcd_pkg::*;

    logic        p_valid_reg;
    logic [47:0] p_prod_reg;
    logic signed [11:0] p_exp_reg;
    logic        p_sign_reg;
    logic        p_special_reg;
    logic [31:0] p_special_val_reg;
    logic        p_last_reg;

    logic        r_valid_reg;
    logic [31:0] r_result_reg;
    logic        r_last_reg;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        za, zb, sign;
    logic        special;
    logic [31:0] special_val;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        za = (ea == 8'd0) && (a[22:0] == 23'd0);
        zb = (eb == 8'd0) && (b[22:0] == 23'd0);
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        sign = a[31] ^ b[31];
        special = 1'b1;
        if (bypass) begin
            special_val = a;
        end else if (ea == 8'hFF && a[22:0] != 23'd0) begin
            special_val = a | 32'h00400000;
        end else if (eb == 8'hFF && b[22:0] != 23'd0) begin
            special_val = b | 32'h00400000;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            special_val = (za || zb) ? 32'h7FC00000 : {sign, 8'hFF, 23'd0};
        end else if (za || zb) begin
            special_val = {sign, 31'd0};
        end else begin
            special = 1'b0;
            special_val = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            p_prod_reg <= ma * mb;
            // Biased exponent of product bit 47 (before normalization).
            p_exp_reg <= 12'($signed({4'd0, (ea == 8'd0) ? 8'd1 : ea})
                       + $signed({4'd0, (eb == 8'd0) ? 8'd1 : eb}) - 12'sd126);
            p_sign_reg <= sign;
            p_special_reg <= special;
            p_special_val_reg <= special_val;
            p_last_reg <= in_last;
        end
    end

    logic [5:0]  lo;
    logic [63:0] norm;
    logic [31:0] rounded;

    always_comb
    begin
        lo = lead_one({16'd0, p_prod_reg});
        norm = {16'd0, p_prod_reg} << (6'd63 - lo);
        rounded = round_pack(p_sign_reg,
                             12'(p_exp_reg - 12'sd47 + $signed({6'd0, lo})), norm);
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            r_result_reg <= p_special_reg ? p_special_val_reg : rounded;
            r_last_reg <= p_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else if (advance) begin
            p_valid_reg <= in_valid;
            r_valid_reg <= p_valid_reg;
        end
    end

    assign out_valid = r_valid_reg;
    assign result = r_result_reg;
    assign out_last = r_last_reg;
endmodule

// ----- rtl/per_channel_dequantizer_top.sv -----
// Top level of the per-channel dequantizer: config registers and pipeline.
// Depends on pcd_pkg, pcd_stream_if, pcd_front and pcd_fmul.
//
//  channel | dir | payload
//  in_s    | in  | mode, raw_value, table_index, scale_bits, zero_point
//  out_s   | out | result_bits, last
//
// One item per cycle while the pipeline is not held. A data item passes the
// table read, int convert, 24x24 multiply and rounding registers in turn.
// The pipeline advances as a whole; it holds when the output stage is full
// and not taken. Reset sets config to defaults, clears counters and valid
// bits; tables are not cleared.
`timescale 1ns / 1ps
module per_channel_dequantizer_top (
    input  logic        clk,
    input  logic        rst_n,
    pcd_stream_if.sink   in_s,
    pcd_stream_if.source out_s,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pcd_pkg::*;

    cfg_t cfg_reg;
    logic advance;
    logic take;
    logic s1_valid, s1_f16, s1_last;
    logic [31:0] s1_value, s1_scale;
    logic m_valid, m_last;
    logic [31:0] m_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.vtype <= VT_F16;
            cfg_reg.channel_count <= 17'd1;
            cfg_reg.inner_size <= 25'd1;
            cfg_reg.param_count <= 9'd1;
            cfg_reg.element_count <= 32'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VALUE_TYPE:    cfg_reg.vtype <= value_type_t'(cfg_data[2:0]);
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[16:0];
                REG_INNER_SIZE:    cfg_reg.inner_size <= cfg_data[24:0];
                REG_PARAM_COUNT:   cfg_reg.param_count <= cfg_data[8:0];
                REG_ELEMENT_COUNT: cfg_reg.element_count <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance = !m_valid || out_s.ready;
    assign in_s.ready = advance;
    assign take = in_s.valid && advance;

    pcd_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .take(take),
        .item(in_s.payload), .advance(advance),
        .s1_valid(s1_valid), .s1_value(s1_value), .s1_scale(s1_scale),
        .s1_is_f16(s1_f16), .s1_last(s1_last)
    );

    pcd_fmul u_fmul (
        .clk(clk), .rst_n(rst_n), .advance(advance), .in_valid(s1_valid),
        .a(s1_value), .b(s1_scale), .bypass(s1_f16), .in_last(s1_last),
        .out_valid(m_valid), .result(m_result), .out_last(m_last)
    );

    assign out_s.valid = m_valid;
    assign out_s.payload.result_bits = m_result;
    assign out_s.payload.last = m_last;
endmodule

// ----- rtl/pcd_checker.sv -----
// Port-level checker for the per-channel dequantizer, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "per_channel_dequantizer_top_assert.svh"
module pcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_bits,
    input logic        out_last
);
    `PCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PCD_ASSERT_NEXT(a_bits_hold, clk, rst_n, out_valid && !out_ready, $stable(out_bits))
    `PCD_ASSERT_NEXT(a_last_hold, clk, rst_n, out_valid && !out_ready, $stable(out_last))
    `PCD_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
    `PCD_ASSERT_IMPL(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind per_channel_dequantizer_top pcd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_s.ready),
    .out_valid(out_s.valid), .out_ready(out_s.ready),
    .out_bits(out_s.payload.result_bits), .out_last(out_s.payload.last)
);
